[hdl/strided_tensor_address_generator_assert.svh]
// Assertion macros used by the address generator top level.
`ifndef STRIDED_TENSOR_ADDRESS_GENERATOR_ASSERT_SVH
`define STRIDED_TENSOR_ADDRESS_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STRTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STRTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/strta_pkg.sv]
// Types, constants and codes of the strided tensor address generator.
package strta_pkg;

  localparam int RANK        = 3;
  localparam int IDX_W       = 32;
  localparam int OFFSET_BITS = 32;
  localparam int PROD_W      = 2 * IDX_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int ST_W        = 3;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [ST_W-1:0] ST_STORAGE  = 3'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

  localparam logic [CFG_AW-1:0] CFG_EXTENT_OUTER  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_EXTENT_MIDDLE = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_EXTENT_INNER  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_STRIDE_OUTER  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_STRIDE_MIDDLE = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_STRIDE_INNER  = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_BASE_OFFSET   = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_STORAGE       = 3'd7;

  typedef struct packed {
    logic              range_err;
    logic [PROD_W-1:0] product;
  } lane_res_t;

  typedef struct packed {
    logic empty;
    logic last;
  } req_meta_t;

endpackage

[hdl/strided_tensor_address_generator.sv]
// Top level of the strided tensor address generator.
// Rank-three strided tensor address generator. Each transaction on the input
// stream is either a walk step (in_tuser = 0), which returns the offset of the
// element the internal row-major counter points at and then advances that
// counter, or a direct access (in_tuser = 1) by the three indices in in_tdata.
// The result carries the element offset in out_tdata, the status in out_tuser
// (0 ok, 1 index out of range, 2 beyond storage, 3 overflow, 4 empty tensor)
// and the wrap of a walk in out_tlast. One transaction is taken per cycle
// while the output is not stalled by out_tready; a result passes through the
// registers of the three axis lanes (range check and 32x32 multiply each), the
// merging adds and status resolution into the output register. Write the
// configuration registers only while no request is in flight.
`include "strided_tensor_address_generator_assert.svh"

module strided_tensor_address_generator
  import strta_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // index_outer [31:0], index_middle [63:32], index_inner [95:64]
  input  logic [RANK*IDX_W-1:0]  in_tdata,
  // req_type
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // element_offset [31:0]
  output logic [OFFSET_BITS-1:0] out_tdata,
  // status [2:0]
  output logic [ST_W-1:0]        out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  logic [IDX_W-1:0]       ext_r    [RANK];
  logic [IDX_W-1:0]       stride_r [RANK];
  logic [OFFSET_BITS-1:0] base_r, storage_r;
  logic [IDX_W-1:0]       walk_r   [RANK];
  logic [IDX_W-1:0]       walk_nxt [RANK];
  logic [IDX_W-1:0]       idx_sel  [RANK];

  logic                   v1_r;
  req_meta_t              meta_r;
  lane_res_t              lane_res [RANK];
  logic                   merge_ready;
  logic                   accept, direct, empty, carry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < RANK; a++) begin
        ext_r[a]    <= IDX_W'(1);
        stride_r[a] <= IDX_W'(1);
      end
      base_r    <= '0;
      storage_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_EXTENT_OUTER:  ext_r[0]    <= cfg_wdata;
        CFG_EXTENT_MIDDLE: ext_r[1]    <= cfg_wdata;
        CFG_EXTENT_INNER:  ext_r[2]    <= cfg_wdata;
        CFG_STRIDE_OUTER:  stride_r[0] <= cfg_wdata;
        CFG_STRIDE_MIDDLE: stride_r[1] <= cfg_wdata;
        CFG_STRIDE_INNER:  stride_r[2] <= cfg_wdata;
        CFG_BASE_OFFSET:   base_r      <= cfg_wdata;
        CFG_STORAGE:       storage_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !v1_r || merge_ready;
  assign accept    = in_tvalid && in_tready;
  assign direct    = in_tuser;

  always_comb begin
    empty = 1'b0;
    for (int a = 0; a < RANK; a++) begin
      if (ext_r[a] == '0) empty = 1'b1;
    end
  end

  // advance the row-major counter, innermost axis fastest
  always_comb begin
    logic [IDX_W:0] n;
    carry = 1'b1;
    for (int a = RANK - 1; a >= 0; a--) begin
      n = {1'b0, walk_r[a]} + 1'b1;
      walk_nxt[a] = walk_r[a];
      if (carry) begin
        if (n < {1'b0, ext_r[a]}) begin
          walk_nxt[a] = n[IDX_W-1:0];
          carry = 1'b0;
        end else begin
          walk_nxt[a] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < RANK; a++) walk_r[a] <= '0;
    end else if (accept && !direct && !empty) begin
      for (int a = 0; a < RANK; a++) walk_r[a] <= walk_nxt[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta_r.empty <= !direct && empty;
      meta_r.last  <= !direct && !empty && carry;
    end
  end

  for (genvar g = 0; g < RANK; g++) begin : g_lane
    assign idx_sel[g] = direct ? in_tdata[g*IDX_W +: IDX_W] : walk_r[g];
    strta_lane u_lane (
      .clk    (clk),
      .en     (accept),
      .idx    (idx_sel[g]),
      .extent (ext_r[g]),
      .stride (stride_r[g]),
      .res    (lane_res[g])
    );
  end

  strta_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v1_r),
    .in_ready   (merge_ready),
    .lane       (lane_res),
    .meta       (meta_r),
    .base       (base_r),
    .storage    (storage_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_offset (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

  `STRTA_ASSERT_NOW(a_last_not_empty, out_tvalid && out_tlast, out_tuser != ST_EMPTY, "last flagged on an empty tensor")
  `STRTA_ASSERT_NOW(a_fail_zero_offset, out_tvalid && (out_tuser != ST_OK), out_tdata == '0, "nonzero offset on a failed transaction")
  `STRTA_ASSERT_NOW(a_ready_when_free, !v1_r, in_tready, "input stalled with lane stage free")
  `STRTA_ASSERT_NEXT(a_direct_keeps_walk, accept && direct, $stable(walk_r[0]) && $stable(walk_r[1]) && $stable(walk_r[2]), "direct access moved the walk counter")

endmodule

[hdl/strta_lane.sv]
// One axis lane: range check and index times stride, registered.
module strta_lane
  import strta_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] idx,
  input  logic [IDX_W-1:0] extent,
  input  logic [IDX_W-1:0] stride,
  output lane_res_t        res
);

  lane_res_t res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.range_err <= (idx >= extent);
      res_r.product   <= PROD_W'(idx) * PROD_W'(stride);
    end
  end

  assign res = res_r;

endmodule

[hdl/strta_merge.sv]
// Merge stages: sum lane products with base, resolve status, hold the result.
module strta_merge
  import strta_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lane_res_t              lane [RANK],
  input  req_meta_t              meta,
  input  logic [OFFSET_BITS-1:0] base,
  input  logic [OFFSET_BITS-1:0] storage,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OFFSET_BITS-1:0] out_offset,
  output logic [ST_W-1:0]        out_status,
  output logic                   out_last
);

  logic                   v2_r, v3_r, vo_r;
  logic                   rdy2, rdy3, rdyo;

  logic [SUM_W-1:0]       sa2_r, p1_2_r, t2_r;
  logic [RANK-1:0]        rng2_r, rng3_r;
  req_meta_t              meta2_r, meta3_r;

  logic [SUM_W-1:0]       s01_3_r, full3_r;
  logic                   o0_3_r;

  logic [OFFSET_BITS-1:0] off_r;
  logic [ST_W-1:0]        st_r;
  logic                   last_r;

  logic [ST_W-1:0]        st_nxt;
  logic                   o1, o2;

  assign rdyo     = !vo_r || out_ready;
  assign rdy3     = !v3_r || rdyo;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= in_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && in_valid) begin
      sa2_r   <= SUM_W'(base) + SUM_W'(lane[0].product);
      p1_2_r  <= SUM_W'(lane[1].product);
      t2_r    <= SUM_W'(lane[1].product) + SUM_W'(lane[2].product);
      rng2_r  <= {lane[2].range_err, lane[1].range_err, lane[0].range_err};
      meta2_r <= meta;
    end
    if (rdy3 && v2_r) begin
      s01_3_r <= sa2_r + p1_2_r;
      full3_r <= sa2_r + t2_r;
      o0_3_r  <= (sa2_r[SUM_W-1:OFFSET_BITS] != '0);
      rng3_r  <= rng2_r;
      meta3_r <= meta2_r;
    end
  end

  assign o1 = (s01_3_r[SUM_W-1:OFFSET_BITS] != '0);
  assign o2 = (full3_r[SUM_W-1:OFFSET_BITS] != '0);

  always_comb begin
    if (meta3_r.empty)                             st_nxt = ST_EMPTY;
    else if (rng3_r[0])                            st_nxt = ST_RANGE;
    else if (o0_3_r)                               st_nxt = ST_OVERFLOW;
    else if (rng3_r[1])                            st_nxt = ST_RANGE;
    else if (o1)                                   st_nxt = ST_OVERFLOW;
    else if (rng3_r[2])                            st_nxt = ST_RANGE;
    else if (o2)                                   st_nxt = ST_OVERFLOW;
    else if (full3_r[OFFSET_BITS-1:0] >= storage)  st_nxt = ST_STORAGE;
    else                                           st_nxt = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rdyo && v3_r) begin
      st_r   <= st_nxt;
      off_r  <= (st_nxt == ST_OK) ? full3_r[OFFSET_BITS-1:0] : '0;
      last_r <= meta3_r.last;
    end
  end

  assign out_valid  = vo_r;
  assign out_offset = off_r;
  assign out_status = st_r;
  assign out_last   = last_r;

endmodule

[sim/tb_strided_tensor_address_generator.sv]
// Self-checking testbench of the strided tensor address generator.
`timescale 1ns / 100ps

module tb_strided_tensor_address_generator
  import strta_pkg::*;
();

  localparam logic REQ_WALK   = 1'b0;
  localparam logic REQ_DIRECT = 1'b1;
  localparam logic [63:0] OFFSET_LIMIT = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic [ST_W-1:0]        status;
    logic                   last;
  } addr_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [RANK*IDX_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OFFSET_BITS-1:0] out_tdata;
  logic [ST_W-1:0]        out_tuser;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [CFG_AW-1:0]      cfg_addr;
  logic [CFG_DW-1:0]      cfg_wdata;

  // Axis 0 is the outermost axis in every array below.
  logic [RANK-1:0][31:0] tensor_ext;
  logic [RANK-1:0][31:0] tensor_stride;
  logic [31:0]           tensor_base;
  logic [31:0]           tensor_storage;
  logic [RANK-1:0][31:0] walk_pos;

  addr_result_t expected_addrs[$];
  int           mismatches;
  int           n_walk;
  int           n_direct;
  int           n_wrap;
  int           n_settings;
  int           status_seen[5];
  logic         steady;

  strided_tensor_address_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [ST_W-1:0] checked_sum(input logic [RANK-1:0][31:0] idx,
                                                   output logic [31:0] off);
    logic [63:0] acc;
    logic [63:0] prod;
    acc = {32'd0, tensor_base};
    off = '0;
    for (int a = 0; a < RANK; a++) begin
      if (idx[a] >= tensor_ext[a]) return ST_RANGE;
      prod = {32'd0, idx[a]} * {32'd0, tensor_stride[a]};
      if (prod > OFFSET_LIMIT || acc > OFFSET_LIMIT - prod) return ST_OVERFLOW;
      acc = acc + prod;
    end
    if (acc >= {32'd0, tensor_storage}) return ST_STORAGE;
    off = acc[31:0];
    return ST_OK;
  endfunction

  function automatic addr_result_t predict_address(input logic req,
                                                   input logic [RANK-1:0][31:0] idx);
    addr_result_t res;
    logic [31:0]  off;
    logic         carry;
    res = '0;
    if (req == REQ_DIRECT) begin
      res.status = checked_sum(idx, off);
    end else if (tensor_ext[0] == 0 || tensor_ext[1] == 0 || tensor_ext[2] == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.status = checked_sum(walk_pos, off);
      carry = 1'b1;
      for (int a = RANK - 1; a >= 0; a--) begin
        if (carry) begin
          if ({1'b0, walk_pos[a]} + 33'd1 < {1'b0, tensor_ext[a]}) begin
            walk_pos[a] = walk_pos[a] + 32'd1;
            carry = 1'b0;
          end else begin
            walk_pos[a] = '0;
          end
        end
      end
      res.last = carry;
    end
    if (res.status == ST_OK) res.offset = off;
    return res;
  endfunction

  function automatic int unsigned pause_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic issue_request(input logic req, input logic [31:0] outer, middle, inner);
    int unsigned       gap;
    logic [RANK-1:0][31:0] idx;
    addr_result_t      res;
    idx = {inner, middle, outer};
    gap = pause_len();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= idx;
    do @(posedge clk); while (!in_tready);
    res = predict_address(req, idx);
    expected_addrs = {expected_addrs, res};
    if (req == REQ_WALK) n_walk++;
    else n_direct++;
    if (res.last) n_wrap++;
    status_seen[res.status]++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_addrs.size() != 0) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_EXTENT_OUTER:  tensor_ext[0]    = data;
      CFG_EXTENT_MIDDLE: tensor_ext[1]    = data;
      CFG_EXTENT_INNER:  tensor_ext[2]    = data;
      CFG_STRIDE_OUTER:  tensor_stride[0] = data;
      CFG_STRIDE_MIDDLE: tensor_stride[1] = data;
      CFG_STRIDE_INNER:  tensor_stride[2] = data;
      CFG_BASE_OFFSET:   tensor_base      = data;
      CFG_STORAGE:       tensor_storage   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_tensor(input logic [31:0] eo, em, ei, so, sm, si, base, storage);
    wait_for_results();
    program_reg(CFG_EXTENT_OUTER, eo);
    program_reg(CFG_EXTENT_MIDDLE, em);
    program_reg(CFG_EXTENT_INNER, ei);
    program_reg(CFG_STRIDE_OUTER, so);
    program_reg(CFG_STRIDE_MIDDLE, sm);
    program_reg(CFG_STRIDE_INNER, si);
    program_reg(CFG_BASE_OFFSET, base);
    program_reg(CFG_STORAGE, storage);
    n_settings++;
  endtask

  function automatic logic [31:0] pick_extent();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 32'd0;
    if (r < 80) return $urandom_range(1, 5);
    if (r < 92) return $urandom_range(6, 40);
    if (r < 97) return $urandom();
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] pick_stride();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'd0;
    if (r < 70) return $urandom_range(1, 16);
    if (r < 85) return $urandom_range(17, 4096);
    if (r < 95) return $urandom();
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] pick_index(input logic [31:0] ext);
    if (ext != 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, ext - 1);
    return $urandom();
  endfunction

  task automatic test_reset_state();
    issue_request(REQ_WALK, 32'd0, 32'd0, 32'd0);
    issue_request(REQ_WALK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(REQ_DIRECT, 32'd0, 32'd0, 32'd0);
    issue_request(REQ_DIRECT, 32'd1, 32'd0, 32'd0);
  endtask

  task automatic test_direct_bounds();
    load_tensor(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1,
                32'd0, 32'hFFFF_FFFF);
    issue_request(REQ_DIRECT, 32'hFFFF_FFFE, 32'd0, 32'd0);
    issue_request(REQ_DIRECT, 32'd0, 32'd0, 32'hFFFF_FFFF);
    load_tensor(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    issue_request(REQ_DIRECT, 32'd1, 32'd0, 32'd0);
    issue_request(REQ_DIRECT, 32'd1, 32'd1, 32'd0);
    issue_request(REQ_DIRECT, 32'd2, 32'hFFFF_FFFF, 32'd0);
    issue_request(REQ_DIRECT, 32'd0, 32'd0, 32'd0);
    load_tensor(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1,
                32'd7, 32'hFFFF_FFFF);
    issue_request(REQ_DIRECT, 32'd3, 32'hFFFF_FFFE, 32'd5);
    wait_for_results();
    program_reg(CFG_EXTENT_MIDDLE, 32'd0);
    issue_request(REQ_DIRECT, 32'd0, 32'd0, 32'd0);
    wait_for_results();
    program_reg(CFG_EXTENT_MIDDLE, 32'd1);
    program_reg(CFG_BASE_OFFSET, 32'hFFFF_FFFF);
    issue_request(REQ_DIRECT, 32'd0, 32'd0, 32'd0);
  endtask

  task automatic test_walk_order();
    load_tensor(32'd1, 32'd2, 32'd2, 32'd6, 32'd2, 32'd1, 32'd10, 32'd100);
    repeat (7) issue_request(REQ_WALK, $urandom(), $urandom(), $urandom());
    // shrink the middle axis under a live counter
    wait_for_results();
    program_reg(CFG_EXTENT_MIDDLE, 32'd1);
    issue_request(REQ_WALK, 32'd0, 32'd0, 32'd0);
    wait_for_results();
    program_reg(CFG_EXTENT_INNER, 32'd0);
    issue_request(REQ_WALK, 32'd0, 32'd0, 32'd0);
  endtask

  task automatic test_random_traffic();
    logic [31:0] eo;
    logic [31:0] em;
    logic [31:0] ei;
    logic [31:0] base;
    logic [31:0] storage;
    int unsigned r;
    for (int ph = 0; ph < 20; ph++) begin
      eo = pick_extent();
      em = pick_extent();
      ei = pick_extent();
      r = $urandom_range(0, 99);
      if (r < 40) base = $urandom_range(0, 1000);
      else if (r < 90) base = $urandom();
      else base = 32'hFFFF_FFFF;
      r = $urandom_range(0, 99);
      if (r < 50) storage = 32'hFFFF_FFFF;
      else if (r < 75) storage = $urandom();
      else if (r < 95) storage = base + $urandom_range(0, 500);
      else storage = 32'd0;
      load_tensor(eo, em, ei, pick_stride(), pick_stride(), pick_stride(), base, storage);
      steady = (ph % 5 == 2);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 1) == 0)
          issue_request(REQ_WALK, $urandom(), $urandom(), $urandom());
        else
          issue_request(REQ_DIRECT, pick_index(eo), pick_index(em), pick_index(ei));
      end
    end
    steady = 1'b0;
  endtask

  initial begin : drive_out_ready
    int unsigned hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        hold = pause_len();
      end
    end
  end

  always @(posedge clk) begin : check_results
    addr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_addrs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: offset %h status %0d last %0b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_addrs.pop_front();
        if (out_tdata !== want.offset || out_tuser !== want.status ||
            out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected offset %h status %0d last %0b, got %h %0d %0b",
                     want.offset, want.status, want.last, out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_WALK;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_EXTENT_OUTER;
    cfg_wdata  = '0;
    steady     = 1'b0;
    mismatches = 0;
    n_walk     = 0;
    n_direct   = 0;
    n_wrap     = 0;
    n_settings = 1;
    for (int s = 0; s < 5; s++) status_seen[s] = 0;
    for (int a = 0; a < RANK; a++) begin
      tensor_ext[a]    = 32'd1;
      tensor_stride[a] = 32'd1;
      walk_pos[a]      = 32'd0;
    end
    tensor_base    = 32'd0;
    tensor_storage = 32'd0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_direct_bounds();
    test_walk_order();
    test_random_traffic();

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("covered %0d requests: %0d walks (%0d wraps), %0d direct, %0d tensor settings",
             n_walk + n_direct, n_walk, n_wrap, n_direct, n_settings);
    $display("status mix: ok %0d, range %0d, storage %0d, overflow %0d, empty %0d",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_STORAGE],
             status_seen[ST_OVERFLOW], status_seen[ST_EMPTY]);
    if (mismatches == 0 && expected_addrs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_addrs.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
